// ===== rtl/bdc_pkg.sv =====
// Shared types and constants for the UART baud divisor calculator.
// No dependencies; imported by every module of the block.
package bdc_pkg;

    localparam int unsigned PCLK_W   = 28;
    localparam int unsigned BAUD_W   = 24;
    localparam int unsigned NUM_W    = 33;
    localparam int unsigned DIV_W    = BAUD_W + 2;
    localparam int unsigned R100_W   = 7;
    localparam int unsigned MANT_W   = 12;
    localparam int unsigned FRAC_W   = 4;
    localparam int unsigned FX_W     = 11;
    localparam int unsigned RECIP_W  = 11;
    localparam int unsigned RECIP_SH = 17;
    localparam int unsigned NCELL    = NUM_W;

    localparam logic [PCLK_W-1:0]  PCLK_RESET = PCLK_W'(16000000);
    localparam logic [NUM_W-1:0]   NUM_RESET  = NUM_W'(400000000);
    localparam logic [4:0]         CENTI_MULT = 5'd25;
    localparam logic [7:0]         CENTI_BASE = 8'd100;
    localparam logic [FX_W-1:0]    ROUND_HALF = FX_W'(50);
    localparam logic [RECIP_W-1:0] RECIP_100  = RECIP_W'(1311);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_BAUD = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic              oversample_by_8;
    } bdc_in_t;

    typedef struct packed {
        logic [15:0]       divisor_word;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] fraction;
        logic [1:0]        status;
    } bdc_out_t;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  div;
        logic [R100_W-1:0] r100;
        logic [MANT_W-1:0] mant;
        logic              ovf;
        logic              by8;
        logic              zero;
    } bdc_cell_t;

endpackage

// ===== rtl/bdc_cell.sv =====
// One step of the divider chain: one quotient bit of clock/baud and one step of the /100.
// Depends on bdc_pkg.
module bdc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  bdc_pkg::bdc_cell_t data_in,
    output logic              ready_up,
    output logic              valid,
    output bdc_pkg::bdc_cell_t data,
    input  logic              ready_dn
);
    import bdc_pkg::*;

    logic             valid_reg;
    bdc_cell_t        data_reg;
    bdc_cell_t        data_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_diff;
    logic             qbit;
    logic [7:0]       t100;
    logic             mbit;

    assign ready_up = !valid_reg || ready_dn;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        rem_sh   = {data_in.rem, data_in.num[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, data_in.div};
        qbit     = rem_sh >= {1'b0, data_in.div};
        t100     = {data_in.r100, qbit};
        mbit     = t100 >= CENTI_BASE;

        data_next      = data_in;
        data_next.num  = {data_in.num[NUM_W-2:0], 1'b0};
        data_next.rem  = qbit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        data_next.r100 = mbit ? R100_W'(t100 - CENTI_BASE) : t100[R100_W-1:0];
        data_next.mant = {data_in.mant[MANT_W-2:0], mbit};
        data_next.ovf  = data_in.ovf | data_in.mant[MANT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/bdc_out.sv =====
// Output stage: rounds the fraction, saturates the mantissa, flags a zero baud rate and holds the result.
// Depends on bdc_pkg.
module bdc_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  bdc_pkg::bdc_cell_t data_in,
    output logic               ready_up,
    output logic               out_valid,
    output bdc_pkg::bdc_out_t  out_data,
    input  logic               out_stall
);
    import bdc_pkg::*;

    logic                      valid_reg;
    bdc_out_t                  data_reg;
    bdc_out_t                  data_next;
    logic [FX_W-1:0]           fx;
    logic [FX_W+RECIP_W-1:0]   prod;
    logic [4:0]                fq;
    logic [FRAC_W-1:0]         frac;
    logic [MANT_W-1:0]         mant;

    assign ready_up  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        fx   = (data_in.by8 ? {1'b0, data_in.r100, 3'b000} : {data_in.r100, 4'b0000})
               + ROUND_HALF;
        prod = {{RECIP_W{1'b0}}, fx} * {{FX_W{1'b0}}, RECIP_100};
        fq   = prod[RECIP_SH+4:RECIP_SH];
        frac = data_in.by8 ? {1'b0, fq[2:0]} : fq[FRAC_W-1:0];
        mant = data_in.ovf ? {MANT_W{1'b1}} : data_in.mant;

        if (data_in.zero)
        begin
            data_next.divisor_word = '0;
            data_next.mantissa     = '0;
            data_next.fraction     = '0;
            data_next.status       = ST_ZERO_BAUD;
        end
        else
        begin
            data_next.divisor_word = {mant, frac};
            data_next.mantissa     = mant;
            data_next.fraction     = frac;
            data_next.status       = data_in.ovf ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/uart_baud_divisor_calc.sv =====
// Top level of the UART baud divisor calculator: config register, cell chain, output stage.
// Depends on bdc_pkg, bdc_cell and bdc_out.
//
//   channel  signals                       direction  transaction when
//   cfg      cfg_we, cfg_wdata             in         cfg_we high
//   in       in_valid, in_stall, in_data   in         in_valid && !in_stall
//   out      out_valid, out_stall, out_data out       out_valid && !out_stall
//
// One transaction per cycle while not stalled; 33 divider cells, one bit
// of 25*pclk_hz each, then the output register.
// Reset loads pclk_hz = 16000000 and empties every stage.
// A stalled output holds; cells behind it fill bubbles before stalling input.
module uart_baud_divisor_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdc_pkg::PCLK_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bdc_pkg::bdc_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bdc_pkg::bdc_out_t             out_data
);
    import bdc_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    bdc_cell_t        head;
    logic             cv    [NCELL+1];
    bdc_cell_t        cd    [NCELL+1];
    logic             crdy  [NCELL+1];

    assign num_next = {5'b0, cfg_wdata} * {{(NUM_W-5){1'b0}}, CENTI_MULT};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= NUM_RESET;
        end
        else if (cfg_we)
        begin
            num_reg <= num_next;
        end
    end

    always_comb
    begin
        head.num  = num_reg;
        head.rem  = '0;
        head.div  = in_data.oversample_by_8 ? {1'b0, in_data.baud_rate, 1'b0}
                                            : {in_data.baud_rate, 2'b00};
        head.r100 = '0;
        head.mant = '0;
        head.ovf  = 1'b0;
        head.by8  = in_data.oversample_by_8;
        head.zero = in_data.baud_rate == '0;
    end

    assign cv[0]    = in_valid;
    assign cd[0]    = head;
    assign in_stall = !crdy[0];

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        bdc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (cv[i]),
            .data_in  (cd[i]),
            .ready_up (crdy[i]),
            .valid    (cv[i+1]),
            .data     (cd[i+1]),
            .ready_dn (crdy[i+1])
        );
    end

    bdc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cv[NCELL]),
        .data_in   (cd[NCELL]),
        .ready_up  (crdy[NCELL]),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

`ifndef SYNTHESIS
    a_sat_mant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_SATURATED |-> out_data.mantissa == {MANT_W{1'b1}})
        else $error("saturated result without full mantissa");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_ZERO_BAUD |-> out_data.divisor_word == '0)
        else $error("zero baud result with nonzero divisor word");

    a_head_open: assert property (@(posedge clk) disable iff (!rst_n)
        !cv[1] |-> !in_stall)
        else $error("input stalled while first cell is empty");

    a_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> crdy[NCELL])
        else $error("output stage refused data while sink is ready");
`endif

endmodule

// ===== verif/tb_uart_baud_divisor_calc.sv =====
// Self-checking testbench for uart_baud_divisor_calc: random-gap driver, random-stall monitor,
// and a divisor predictor checked against every output transaction across clock settings.
// Depends on bdc_pkg and the uart_baud_divisor_calc RTL.
module tb_uart_baud_divisor_calc;
    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 40;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [PCLK_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    bdc_in_t           in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    bdc_out_t          out_data;

    bdc_in_t           request_q[$];
    bdc_out_t          divisor_q[$];
    logic [PCLK_W-1:0] pclk_cfg       = PCLK_RESET;
    int unsigned       send_gap_pct   = 38;
    int unsigned       recv_stall_pct = 38;
    int unsigned       err_count      = 0;

    uart_baud_divisor_calc i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic bdc_out_t calc_divisor(bdc_in_t req, logic [PCLK_W-1:0] pclk);
        logic [63:0] centi;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] frac;
        bdc_out_t    res;
        res = '0;
        if (req.baud_rate == '0)
        begin
            res.status = ST_ZERO_BAUD;
            return res;
        end
        if (req.oversample_by_8)
            centi = (64'(CENTI_MULT) * 64'(pclk)) / (64'd2 * 64'(req.baud_rate));
        else
            centi = (64'(CENTI_MULT) * 64'(pclk)) / (64'd4 * 64'(req.baud_rate));
        mant = centi / 64'(CENTI_BASE);
        rem  = centi - mant * 64'(CENTI_BASE);
        if (req.oversample_by_8)
            frac = ((rem * 64'd8 + 64'(ROUND_HALF)) / 64'(CENTI_BASE)) & 64'h7;
        else
            frac = ((rem * 64'd16 + 64'(ROUND_HALF)) / 64'(CENTI_BASE)) & 64'hF;
        res.status = ST_OK;
        if (mant > 64'd4095)
        begin
            mant       = 64'd4095;
            res.status = ST_SATURATED;
        end
        res.mantissa     = mant[MANT_W-1:0];
        res.fraction     = frac[FRAC_W-1:0];
        res.divisor_word = {mant[MANT_W-1:0], frac[FRAC_W-1:0]};
        return res;
    endfunction

    function automatic logic [BAUD_W-1:0] pick_baud();
        logic [BAUD_W-1:0] std_rates[10];
        std_rates = '{300, 1200, 2400, 9600, 19200, 38400, 57600, 115200, 921600, 3000000};
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return BAUD_W'($urandom);
            3, 4, 5: return std_rates[$urandom_range(9)];
            6, 7:    return BAUD_W'($urandom_range(12500000, 1));
            8:       return BAUD_W'($urandom_range(4000, 1));
            default: return BAUD_W'($urandom_range(300, 1));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_request(input logic [BAUD_W-1:0] baud, input logic by8);
        bdc_in_t req;
        req.baud_rate       = baud;
        req.oversample_by_8 = by8;
        request_q.push_back(req);
    endtask

    task automatic drain_all();
        while (request_q.size() != 0 || divisor_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_pclk(input logic [PCLK_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pclk_cfg  = value;
    endtask

    // driver: advance only when the current transaction is taken or none is pending
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                divisor_q.push_back(calc_divisor(in_data, pclk_cfg));
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_data  <= request_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        bdc_out_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (divisor_q.size() == 0)
                    flag_mismatch("unexpected transaction", out_data.divisor_word, 0);
                else
                begin
                    want = divisor_q.pop_front();
                    if (out_data.divisor_word !== want.divisor_word)
                        flag_mismatch("divisor_word", out_data.divisor_word, want.divisor_word);
                    if (out_data.mantissa !== want.mantissa)
                        flag_mismatch("mantissa", out_data.mantissa, want.mantissa);
                    if (out_data.fraction !== want.fraction)
                        flag_mismatch("fraction", out_data.fraction, want.fraction);
                    if (out_data.status !== want.status)
                        flag_mismatch("status", out_data.status, want.status);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        logic [PCLK_W-1:0] pclk_plan[8];
        pclk_plan = '{PCLK_W'(1), PCLK_W'(200000000), '1, '0,
                      PCLK_W'($urandom_range(200000000, 1)), PCLK_W'($urandom),
                      PCLK_W'($urandom_range(50000000, 1000000)), PCLK_RESET};

        // zero baud, baud extremes, standard rates, saturation edge, fraction wrap
        queue_request('0, 1'b1);
        queue_request('0, 1'b0);
        queue_request(BAUD_W'(1), 1'b1);
        queue_request(BAUD_W'(1), 1'b0);
        queue_request('1, 1'b1);
        queue_request('1, 1'b0);
        queue_request(BAUD_W'(12500000), 1'b1);
        queue_request(BAUD_W'(12500000), 1'b0);
        queue_request(BAUD_W'(9600), 1'b1);
        queue_request(BAUD_W'(9600), 1'b0);
        queue_request(BAUD_W'(115200), 1'b1);
        queue_request(BAUD_W'(115200), 1'b0);
        queue_request(BAUD_W'(245), 1'b0);
        queue_request(BAUD_W'(244), 1'b0);
        queue_request(BAUD_W'(9951), 1'b1);
        queue_request(BAUD_W'(9903), 1'b0);
        queue_request(BAUD_W'(24'hAAAAAA), 1'b1);
        queue_request(BAUD_W'(24'h555555), 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (pclk_plan[p])
        begin
            drain_all();
            load_pclk(pclk_plan[p]);
            send_gap_pct   = (p == 4) ? 0 : 38;
            recv_stall_pct = (p == 4) ? 0 : 38;
            repeat (180) queue_request(pick_baud(), 1'($urandom));
        end
        drain_all();

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
